FILE: rtl/wvt_pkg.sv
// ----------------------------------------------------------------------------
// wvt_pkg
// Shared types, constants and fixed-point helpers for the wireframe vertex
// transform unit.
// ----------------------------------------------------------------------------
package wvt_pkg;

  localparam int COORD_W    = 32;
  localparam int WIDE_W     = 64;
  localparam int TRIG_W     = 16;
  localparam int COLOR_W    = 24;
  localparam int INDEX_W    = 10;
  localparam int HEIGHT_W   = 16;
  localparam int SCALE_W    = 8;
  localparam int OFFS_W     = 16;
  localparam int SCREEN_W   = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Height gain is Q4.12
  localparam int unsigned ZGAIN_FRAC = 12;

  // cos(30 deg) with 30 fraction bits, rounded to nearest at the trig precision later
  localparam longint COS30_Q30 = 64'd929887697;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  localparam wide_t COORD_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam wide_t COORD_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE       = 3'd0,
    REG_PRE_OFFSET  = 3'd1,
    REG_Z_GAIN      = 3'd2,
    REG_ROT_X       = 3'd3,
    REG_ROT_Y       = 3'd4,
    REG_ROT_Z       = 3'd5,
    REG_PROJ_MODE   = 3'd6,
    REG_POST_OFFSET = 3'd7
  } cfg_reg_e;

  // Configuration as seen by the datapath (signed halves cast at use)
  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [OFFS_W-1:0]  pre_x;
    logic [OFFS_W-1:0]  pre_y;
    logic [TRIG_W-1:0]  z_gain;
    logic [TRIG_W-1:0]  rx_sin;
    logic [TRIG_W-1:0]  rx_cos;
    logic [TRIG_W-1:0]  ry_sin;
    logic [TRIG_W-1:0]  ry_cos;
    logic [TRIG_W-1:0]  rz_sin;
    logic [TRIG_W-1:0]  rz_cos;
    logic               proj_iso;
    logic [OFFS_W-1:0]  post_x;
    logic [OFFS_W-1:0]  post_y;
  } cfg_t;

  // Arithmetic shift right that truncates toward zero
  function automatic wide_t trunc_shr(wide_t v, int unsigned sh);
    wide_t bias;
    bias = v[WIDE_W-1] ? ((wide_t'(1) <<< sh) - wide_t'(1)) : '0;
    return (v + bias) >>> sh;
  endfunction

  // Clamp to the signed 32-bit coordinate range
  function automatic coord_t sat_coord(wide_t v);
    coord_t r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/wvt_prep.sv
// ----------------------------------------------------------------------------
// wvt_prep
// Scales grid indices and height, removes the pre-offset and applies the
// height gain. Three register stages.
// ----------------------------------------------------------------------------
module wvt_prep #(
  parameter int GRID_SIZE = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wvt_pkg::cfg_t                        cfg_i,
  input  logic                                 valid_i,
  input  logic        [wvt_pkg::INDEX_W-1:0]   col_index_i,
  input  logic        [wvt_pkg::INDEX_W-1:0]   row_index_i,
  input  logic signed [wvt_pkg::HEIGHT_W-1:0]  height_i,
  input  logic        [wvt_pkg::COLOR_W-1:0]   color_i,
  output logic                                 valid_o,
  output wvt_pkg::coord_t                      x_o,
  output wvt_pkg::coord_t                      y_o,
  output wvt_pkg::coord_t                      z_o,
  output logic        [wvt_pkg::COLOR_W-1:0]   color_o
);

  localparam int POS_W  = wvt_pkg::INDEX_W + wvt_pkg::SCALE_W;
  localparam int HSF_W  = wvt_pkg::HEIGHT_W + wvt_pkg::SCALE_W + 1;
  localparam int ZP_W   = HSF_W + wvt_pkg::TRIG_W;
  localparam logic [16:0] GRID_MAX = 17'(GRID_SIZE - 1);

  logic [wvt_pkg::INDEX_W-1:0] col_lim, row_lim;

  logic                         v1_q, v2_q, v3_q;
  logic [POS_W-1:0]             colsf_q, rowsf_q;
  logic signed [HSF_W-1:0]      hsf_q;
  logic [wvt_pkg::COLOR_W-1:0]  c1_q, c2_q, c3_q;
  wvt_pkg::coord_t              x2_q, y2_q, x3_q, y3_q, z3_q;
  logic signed [ZP_W-1:0]       zp_q;

  // Clamp indices to the grid
  always_comb begin
    col_lim = ({7'd0, col_index_i} > GRID_MAX) ? GRID_MAX[wvt_pkg::INDEX_W-1:0] : col_index_i;
    row_lim = ({7'd0, row_index_i} > GRID_MAX) ? GRID_MAX[wvt_pkg::INDEX_W-1:0] : row_index_i;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: scale indices and height
  always_ff @(posedge clk_i) begin
    colsf_q <= POS_W'(col_lim) * POS_W'(cfg_i.scale);
    rowsf_q <= POS_W'(row_lim) * POS_W'(cfg_i.scale);
    hsf_q   <= HSF_W'(height_i) * $signed({{(HSF_W-wvt_pkg::SCALE_W){1'b0}}, cfg_i.scale});
    c1_q    <= color_i;
  end

  // Stage 2: remove pre-offset, apply height gain
  always_ff @(posedge clk_i) begin
    x2_q <= $signed({{(wvt_pkg::COORD_W-POS_W){1'b0}}, colsf_q})
            - wvt_pkg::COORD_W'($signed(cfg_i.pre_x));
    y2_q <= $signed({{(wvt_pkg::COORD_W-POS_W){1'b0}}, rowsf_q})
            - wvt_pkg::COORD_W'($signed(cfg_i.pre_y));
    zp_q <= ZP_W'(hsf_q) * ZP_W'($signed(cfg_i.z_gain));
    c2_q <= c1_q;
  end

  // Stage 3: drop the gain fraction bits
  always_ff @(posedge clk_i) begin
    x3_q <= x2_q;
    y3_q <= y2_q;
    z3_q <= wvt_pkg::sat_coord(wvt_pkg::trunc_shr(wvt_pkg::WIDE_W'(zp_q),
                                                  wvt_pkg::ZGAIN_FRAC));
    c3_q <= c2_q;
  end

  assign valid_o = v3_q;
  assign x_o     = x3_q;
  assign y_o     = y3_q;
  assign z_o     = z3_q;
  assign color_o = c3_q;

endmodule

FILE: rtl/wvt_rotate.sv
// ----------------------------------------------------------------------------
// wvt_rotate
// Plane rotation of one coordinate pair: a' = a*c - b*s, b' = a*s + b*c,
// truncated toward zero and clamped. Products in stage one, sums in stage two.
// ----------------------------------------------------------------------------
module wvt_rotate #(
  parameter int FRAC   = 14,
  parameter int SIDE_W = 56
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  wvt_pkg::coord_t                    a_i,
  input  wvt_pkg::coord_t                    b_i,
  input  logic signed [wvt_pkg::TRIG_W-1:0]  sin_i,
  input  logic signed [wvt_pkg::TRIG_W-1:0]  cos_i,
  input  logic        [SIDE_W-1:0]           side_i,
  output logic                               valid_o,
  output wvt_pkg::coord_t                    a_o,
  output wvt_pkg::coord_t                    b_o,
  output logic        [SIDE_W-1:0]           side_o
);

  localparam int PROD_W = wvt_pkg::COORD_W + wvt_pkg::TRIG_W;

  logic                     v1_q, v2_q;
  logic signed [PROD_W-1:0] pac_q, pbs_q, pas_q, pbc_q;
  logic [SIDE_W-1:0]        s1_q, s2_q;
  wvt_pkg::coord_t          a2_q, b2_q;
  wvt_pkg::wide_t           sum_a, sum_b;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Stage 1: four products
  always_ff @(posedge clk_i) begin
    pac_q <= PROD_W'(a_i) * PROD_W'(cos_i);
    pbs_q <= PROD_W'(b_i) * PROD_W'(sin_i);
    pas_q <= PROD_W'(a_i) * PROD_W'(sin_i);
    pbc_q <= PROD_W'(b_i) * PROD_W'(cos_i);
    s1_q  <= side_i;
  end

  // Combine products
  always_comb begin
    sum_a = wvt_pkg::WIDE_W'(pac_q) - wvt_pkg::WIDE_W'(pbs_q);
    sum_b = wvt_pkg::WIDE_W'(pas_q) + wvt_pkg::WIDE_W'(pbc_q);
  end

  // Stage 2: drop trig fraction bits and clamp
  always_ff @(posedge clk_i) begin
    a2_q <= wvt_pkg::sat_coord(wvt_pkg::trunc_shr(sum_a, FRAC));
    b2_q <= wvt_pkg::sat_coord(wvt_pkg::trunc_shr(sum_b, FRAC));
    s2_q <= s1_q;
  end

  assign valid_o = v2_q;
  assign a_o     = a2_q;
  assign b_o     = b2_q;
  assign side_o  = s2_q;

endmodule

FILE: rtl/wvt_project.sv
// ----------------------------------------------------------------------------
// wvt_project
// Optional isometric projection, post-offset and 16-bit clamp of the screen
// point. Four register stages, the last one drives the result ports.
// ----------------------------------------------------------------------------
module wvt_project #(
  parameter int FRAC = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wvt_pkg::cfg_t                        cfg_i,
  input  logic                                 valid_i,
  input  wvt_pkg::coord_t                      x_i,
  input  wvt_pkg::coord_t                      y_i,
  input  wvt_pkg::coord_t                      z_i,
  input  logic        [wvt_pkg::COLOR_W-1:0]   color_i,
  output logic                                 valid_o,
  output logic signed [wvt_pkg::SCREEN_W-1:0]  screen_x_o,
  output logic signed [wvt_pkg::SCREEN_W-1:0]  screen_y_o,
  output logic        [wvt_pkg::COLOR_W-1:0]   color_o
);

  localparam int     SUM_W     = wvt_pkg::COORD_W + 1;
  localparam int     ISO_W     = SUM_W + FRAC + 1;
  localparam longint ISO_COS30 = (((wvt_pkg::COS30_Q30 * 2) >> (30 - FRAC)) + 1) >> 1;
  localparam logic signed [ISO_W-1:0] C30_K = ISO_W'(ISO_COS30);
  localparam logic signed [SUM_W-1:0] SCR_MAX = 33'sh0_0000_7FFF;
  localparam logic signed [SUM_W-1:0] SCR_MIN = 33'sh1_FFFF_8000;

  logic                         v1_q, v2_q, v3_q, v4_q;
  logic signed [SUM_W-1:0]      dif1_q, sum1_q;
  wvt_pkg::coord_t              x1_q, y1_q, z1_q, x2_q, y2_q, z2_q, x3_q, y3_q;
  logic [wvt_pkg::COLOR_W-1:0]  c1_q, c2_q, c3_q, c4_q;
  logic signed [ISO_W-1:0]      prod2_q;
  wvt_pkg::wide_t               half_d;
  logic signed [SUM_W-1:0]      half2_q;
  wvt_pkg::coord_t              iso_x, iso_y;
  logic signed [SUM_W-1:0]      px, py;
  logic signed [wvt_pkg::SCREEN_W-1:0] sx_d, sy_d, sx_q, sy_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 1: difference and sum of x and y
  always_ff @(posedge clk_i) begin
    dif1_q <= SUM_W'(x_i) - SUM_W'(y_i);
    sum1_q <= SUM_W'(x_i) + SUM_W'(y_i);
    x1_q   <= x_i;
    y1_q   <= y_i;
    z1_q   <= z_i;
    c1_q   <= color_i;
  end

  // sin30 is one half: the y term is the sum halved toward zero
  assign half_d = wvt_pkg::trunc_shr(wvt_pkg::WIDE_W'(sum1_q), 1);

  // Stage 2: cos30 product and halved sum
  always_ff @(posedge clk_i) begin
    prod2_q <= ISO_W'(dif1_q) * C30_K;
    half2_q <= half_d[SUM_W-1:0];
    x2_q    <= x1_q;
    y2_q    <= y1_q;
    z2_q    <= z1_q;
    c2_q    <= c1_q;
  end

  // Isometric coordinates
  always_comb begin
    iso_x = wvt_pkg::sat_coord(wvt_pkg::trunc_shr(wvt_pkg::WIDE_W'(prod2_q), FRAC));
    iso_y = wvt_pkg::sat_coord(wvt_pkg::WIDE_W'(half2_q) - wvt_pkg::WIDE_W'(z2_q));
  end

  // Stage 3: select view
  always_ff @(posedge clk_i) begin
    x3_q <= cfg_i.proj_iso ? iso_x : x2_q;
    y3_q <= cfg_i.proj_iso ? iso_y : y2_q;
    c3_q <= c2_q;
  end

  // Add post-offset and clamp to the screen range
  always_comb begin
    px = SUM_W'(x3_q) + SUM_W'($signed(cfg_i.post_x));
    py = SUM_W'(y3_q) + SUM_W'($signed(cfg_i.post_y));
    if (px > SCR_MAX) begin
      sx_d = SCR_MAX[wvt_pkg::SCREEN_W-1:0];
    end else if (px < SCR_MIN) begin
      sx_d = SCR_MIN[wvt_pkg::SCREEN_W-1:0];
    end else begin
      sx_d = px[wvt_pkg::SCREEN_W-1:0];
    end
    if (py > SCR_MAX) begin
      sy_d = SCR_MAX[wvt_pkg::SCREEN_W-1:0];
    end else if (py < SCR_MIN) begin
      sy_d = SCR_MIN[wvt_pkg::SCREEN_W-1:0];
    end else begin
      sy_d = py[wvt_pkg::SCREEN_W-1:0];
    end
  end

  // Stage 4: output register
  always_ff @(posedge clk_i) begin
    sx_q <= sx_d;
    sy_q <= sy_d;
    c4_q <= c3_q;
  end

  assign valid_o    = v4_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;
  assign color_o    = c4_q;

endmodule

FILE: rtl/wireframe_vertex_transform_unit.sv
// ----------------------------------------------------------------------------
// wireframe_vertex_transform_unit
// Turns one height-map vertex into one screen point: scale, offset, rotate
// about x, y and z, optional isometric projection, post-offset and clamp.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------
//  vertex in | start, busy          | col_index_i row_index_i height_i color_i
//  point out | done_o (strobe)      | screen_x_o screen_y_o color_out_o
//  config    | cfg_we_i, cfg_idx_i  | cfg_data_i
//
//  One vertex is taken per cycle; busy is always low and the receiver cannot stall.
//  The pipeline has 3 prep stages, 2 per rotation axis and 4 projection
//  stages.
//  Reset clears the valid bits and loads the register reset values.
//  Each point is shown on the result ports for one cycle with done_o high.
// ----------------------------------------------------------------------------
module wireframe_vertex_transform_unit #(
  parameter int GRID_SIZE      = 1024,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic        [wvt_pkg::INDEX_W-1:0]     col_index_i,
  input  logic        [wvt_pkg::INDEX_W-1:0]     row_index_i,
  input  logic signed [wvt_pkg::HEIGHT_W-1:0]    height_i,
  input  logic        [wvt_pkg::COLOR_W-1:0]     color_i,
  input  logic                                   cfg_we_i,
  input  logic        [wvt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic        [wvt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                                   done_o,
  output logic signed [wvt_pkg::SCREEN_W-1:0]    screen_x_o,
  output logic signed [wvt_pkg::SCREEN_W-1:0]    screen_y_o,
  output logic        [wvt_pkg::COLOR_W-1:0]     color_out_o
);

  localparam int SIDE_W = wvt_pkg::COORD_W + wvt_pkg::COLOR_W;

  // Register values after reset
  localparam wvt_pkg::cfg_t CFG_RESET = '{
    scale:    8'd1,
    pre_x:    '0,
    pre_y:    '0,
    z_gain:   16'd410,
    rx_sin:   '0,
    rx_cos:   16'd16384,
    ry_sin:   '0,
    ry_cos:   16'd16384,
    rz_sin:   '0,
    rz_cos:   16'd16384,
    proj_iso: 1'b1,
    post_x:   '0,
    post_y:   '0
  };

  wvt_pkg::cfg_t cfg_d, cfg_q;

  logic                        in_take;
  logic                        pv, rxv, ryv, rzv;
  wvt_pkg::coord_t             px, py, pz;
  logic [wvt_pkg::COLOR_W-1:0] pc;
  wvt_pkg::coord_t             rx_a, rx_b, ry_a, ry_b, rz_a, rz_b;
  logic [SIDE_W-1:0]           rx_side, ry_side, rz_side;

  // Pipeline never holds off a transaction
  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (wvt_pkg::cfg_reg_e'(cfg_idx_i))
        wvt_pkg::REG_SCALE:       cfg_d.scale = cfg_data_i[wvt_pkg::SCALE_W-1:0];
        wvt_pkg::REG_PRE_OFFSET:  {cfg_d.pre_x, cfg_d.pre_y} = cfg_data_i;
        wvt_pkg::REG_Z_GAIN:      cfg_d.z_gain = cfg_data_i[wvt_pkg::TRIG_W-1:0];
        wvt_pkg::REG_ROT_X:       {cfg_d.rx_sin, cfg_d.rx_cos} = cfg_data_i;
        wvt_pkg::REG_ROT_Y:       {cfg_d.ry_sin, cfg_d.ry_cos} = cfg_data_i;
        wvt_pkg::REG_ROT_Z:       {cfg_d.rz_sin, cfg_d.rz_cos} = cfg_data_i;
        wvt_pkg::REG_PROJ_MODE:   cfg_d.proj_iso = cfg_data_i[0];
        wvt_pkg::REG_POST_OFFSET: {cfg_d.post_x, cfg_d.post_y} = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Scale and offset
  wvt_prep #(
    .GRID_SIZE (GRID_SIZE)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (in_take),
    .col_index_i (col_index_i),
    .row_index_i (row_index_i),
    .height_i    (height_i),
    .color_i     (color_i),
    .valid_o     (pv),
    .x_o         (px),
    .y_o         (py),
    .z_o         (pz),
    .color_o     (pc)
  );

  // Roll: rotate (y, z), carry x
  wvt_rotate #(
    .FRAC   (TRIG_FRAC_BITS),
    .SIDE_W (SIDE_W)
  ) u_rot_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pv),
    .a_i     (py),
    .b_i     (pz),
    .sin_i   ($signed(cfg_q.rx_sin)),
    .cos_i   ($signed(cfg_q.rx_cos)),
    .side_i  ({px, pc}),
    .valid_o (rxv),
    .a_o     (rx_a),
    .b_o     (rx_b),
    .side_o  (rx_side)
  );

  // Pitch: rotate (z, x), carry y
  wvt_rotate #(
    .FRAC   (TRIG_FRAC_BITS),
    .SIDE_W (SIDE_W)
  ) u_rot_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rxv),
    .a_i     (rx_b),
    .b_i     (rx_side[SIDE_W-1:wvt_pkg::COLOR_W]),
    .sin_i   ($signed(cfg_q.ry_sin)),
    .cos_i   ($signed(cfg_q.ry_cos)),
    .side_i  ({rx_a, rx_side[wvt_pkg::COLOR_W-1:0]}),
    .valid_o (ryv),
    .a_o     (ry_a),
    .b_o     (ry_b),
    .side_o  (ry_side)
  );

  // Yaw: rotate (x, y), carry z
  wvt_rotate #(
    .FRAC   (TRIG_FRAC_BITS),
    .SIDE_W (SIDE_W)
  ) u_rot_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ryv),
    .a_i     (ry_b),
    .b_i     (ry_side[SIDE_W-1:wvt_pkg::COLOR_W]),
    .sin_i   ($signed(cfg_q.rz_sin)),
    .cos_i   ($signed(cfg_q.rz_cos)),
    .side_i  ({ry_a, ry_side[wvt_pkg::COLOR_W-1:0]}),
    .valid_o (rzv),
    .a_o     (rz_a),
    .b_o     (rz_b),
    .side_o  (rz_side)
  );

  // Project and place on screen
  wvt_project #(
    .FRAC (TRIG_FRAC_BITS)
  ) u_project (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (rzv),
    .x_i        (rz_a),
    .y_i        (rz_b),
    .z_i        (rz_side[SIDE_W-1:wvt_pkg::COLOR_W]),
    .color_i    (rz_side[wvt_pkg::COLOR_W-1:0]),
    .valid_o    (done_o),
    .screen_x_o (screen_x_o),
    .screen_y_o (screen_y_o),
    .color_o    (color_out_o)
  );

endmodule
